// ===== rtl/fwoh_pkg.sv =====
// Shared codes and field widths for the occupancy-histogram FIFO.
`timescale 1ns / 1ps

package fwoh_pkg;

    // Queue depth; the 5-bit size fields cover up to 31 entries
    localparam int DEPTH   = 16;

    // Field widths of a request
    localparam int OP_W    = 3;
    localparam int ID_W    = 16;
    localparam int TIME_W  = 32;
    localparam int BIDX_W  = 5;

    // Field widths of a result
    localparam int STAT_W  = 2;
    localparam int SIZE_W  = 5;
    localparam int BIN_W   = 48;

    // Bus widths
    localparam int S_TDATA_W = 56;   // 16 + 32 + 5 = 53, padded to bytes
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 112;  // 16 + 32 + 5 + 5 + 48 = 106, padded
    localparam int M_TUSER_W = 3;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ADD      = 3'd0;
    localparam logic [OP_W-1:0] OP_TAKE     = 3'd1;
    localparam logic [OP_W-1:0] OP_END      = 3'd2;
    localparam logic [OP_W-1:0] OP_RESTART  = 3'd3;
    localparam logic [OP_W-1:0] OP_DRAIN    = 3'd4;
    localparam logic [OP_W-1:0] OP_READ_BIN = 3'd5;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    // Queue kinds
    localparam logic [1:0] KIND_NORMAL = 2'd0;
    localparam logic [1:0] KIND_EXIT   = 2'd1;
    localparam logic [1:0] KIND_ENTRY  = 2'd2;

endpackage

// ===== rtl/fifo_with_occupancy_histogram.sv =====
// Timestamped ID FIFO with a saturating occupancy-time histogram.
//
// Usage:
//   Requests enter on s_axis (tuser = operation; tdata = entity_id,
//   current_time, bin_index from bit 0 up). Results leave on m_axis
//   (tuser = status, wait_valid; tdata = entity_out, wait_time,
//   queue_size, high_water, bin_time; tlast marks the final result).
//   The queue kind register is written through i_cfg_wr_en/i_cfg_wr_data.
//   Each request is accepted in the idle state; the accepting edge starts the
//   registered reads of the ID/time memory and the histogram bin memory,
//   and the execute state then updates, writes back and loads the output
//   register, which raises m_axis_tvalid. A new request is not accepted
//   until the execute state has finished, as s_axis_tready is high only in idle.
//   A drain emits one popped entry per cycle while m_axis is not stalled,
//   the next read overlapping the write-back of the current one.
//   A new request is taken while a result still waits in the output
//   register; the update cycle then holds until the receiver takes it,
//   so a stall on m_axis holds all state and nothing is lost.
//   Reset (synchronous, active low) empties the queue, clears high-water
//   mark, last time and queue kind, and clears all bins at once through
//   per-bin valid bits.
`timescale 1ns / 1ps

module fifo_with_occupancy_histogram
    import fwoh_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [1:0]           i_cfg_wr_data,   // queue_kind
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,    // entity_id, current_time, bin_index
    input  logic [S_TUSER_W-1:0] s_axis_tuser,    // operation
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,    // entity_out, wait_time, queue_size,
                                                  // high_water, bin_time
    output logic [M_TUSER_W-1:0] m_axis_tuser,    // status, wait_valid
    output logic                 m_axis_tlast
);

    localparam int PTR_W  = $clog2(DEPTH);
    localparam int OCC_W  = $clog2(DEPTH + 1);
    localparam int NBIN   = DEPTH + 1;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    // Control state
    t_state             r_state;
    logic [1:0]         r_kind;
    logic [PTR_W-1:0]   r_head;
    logic [PTR_W-1:0]   r_tail;
    logic [OCC_W-1:0]   r_occ;
    logic [OCC_W-1:0]   r_max;
    logic [TIME_W-1:0]  r_last_time;
    logic [NBIN-1:0]    r_bin_vld;

    // Latched request
    logic [OP_W-1:0]    r_op;
    logic [ID_W-1:0]    r_ent;
    logic [TIME_W-1:0]  r_time;
    logic               r_bidx_oob;
    logic [OCC_W-1:0]   r_bin_addr;

    // Memories and their read registers
    logic [ID_W-1:0]    mem_id   [DEPTH];
    logic [TIME_W-1:0]  mem_time [DEPTH];
    logic [BIN_W-1:0]   mem_bin  [NBIN];
    logic [ID_W-1:0]    r_rd_id;
    logic [TIME_W-1:0]  r_rd_time;
    logic [BIN_W-1:0]   r_rd_bin;
    logic               r_rd_bin_vld;

    // Output register
    logic               r_m_valid;
    logic [M_TDATA_W-1:0] r_m_tdata;
    logic [M_TUSER_W-1:0] r_m_tuser;
    logic               r_m_tlast;

    // Next values
    t_state             n_state;
    logic [PTR_W-1:0]   n_head;
    logic [PTR_W-1:0]   n_tail;
    logic [OCC_W-1:0]   n_occ;
    logic [OCC_W-1:0]   n_max;
    logic [TIME_W-1:0]  n_last_time;
    logic [STAT_W-1:0]  n_status;
    logic [ID_W-1:0]    n_ent_out;
    logic [TIME_W-1:0]  n_wait;
    logic               n_wait_vld;
    logic [BIN_W-1:0]   n_bin_out;
    logic               n_last;

    // Request fields
    logic               w_accept;
    logic [OP_W-1:0]    w_in_op;
    logic [BIDX_W-1:0]  w_in_bidx;
    logic               w_in_oob;
    logic [OCC_W-1:0]   w_bin_raddr;

    // Datapath helpers
    logic               w_exec;
    logic               w_bin_we;
    logic               w_fifo_we;
    logic               w_fifo_re;
    logic [PTR_W-1:0]   w_fifo_raddr;
    logic [PTR_W-1:0]   w_head_inc;
    logic [PTR_W-1:0]   w_tail_inc;
    logic [OCC_W-1:0]   w_occ_inc;
    logic [OCC_W-1:0]   w_occ_dec;
    logic [TIME_W-1:0]  w_elapsed;
    logic [BIN_W-1:0]   w_bin_cur;
    logic [BIN_W:0]     w_bin_sum;
    logic [BIN_W-1:0]   w_bin_new;
    logic               w_full;
    logic               w_empty;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_in_op       = s_axis_tuser[OP_W-1:0];
    assign w_in_bidx     = s_axis_tdata[ID_W+TIME_W +: BIDX_W];
    assign w_in_oob      = (32'(w_in_bidx) > 32'(DEPTH));

    // Pick the bin to read: requested bin for read-bin, else current size
    assign w_bin_raddr = (w_in_op != OP_READ_BIN) ? r_occ :
                         (w_in_oob ? '0 : OCC_W'(w_in_bidx));

    assign w_exec     = (r_state == S_EXEC) && (!r_m_valid || m_axis_tready);
    assign w_head_inc = (r_head == PTR_W'(DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign w_tail_inc = (r_tail == PTR_W'(DEPTH - 1)) ? '0 : r_tail + 1'b1;
    assign w_occ_inc  = r_occ + 1'b1;
    assign w_occ_dec  = r_occ - 1'b1;
    assign w_full     = (r_occ == OCC_W'(DEPTH));
    assign w_empty    = (r_occ == '0);

    // Saturating bin charge
    assign w_elapsed = r_time - r_last_time;
    assign w_bin_cur = r_rd_bin_vld ? r_rd_bin : '0;
    assign w_bin_sum = {1'b0, w_bin_cur} + (BIN_W + 1)'(w_elapsed);
    assign w_bin_new = w_bin_sum[BIN_W] ? '1 : w_bin_sum[BIN_W-1:0];

    // Operation decode and next state
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_occ       = r_occ;
        n_max       = r_max;
        n_last_time = r_last_time;
        n_status    = ST_OK;
        n_ent_out   = '0;
        n_wait      = '0;
        n_wait_vld  = 1'b0;
        n_bin_out   = '0;
        n_last      = 1'b1;
        w_bin_we    = 1'b0;
        w_fifo_we   = 1'b0;
        w_fifo_re   = w_accept;

        if (w_accept) begin
            n_state = S_EXEC;
        end

        if (w_exec) begin
            n_state = S_IDLE;
            unique case (r_op)
                OP_ADD: begin
                    w_bin_we    = 1'b1;
                    n_last_time = r_time;
                    if (w_full) begin
                        n_status = ST_FULL;
                    end else begin
                        w_fifo_we = 1'b1;
                        n_tail    = w_tail_inc;
                        n_occ     = w_occ_inc;
                        if (w_occ_inc > r_max) begin
                            n_max = w_occ_inc;
                        end
                    end
                end
                OP_TAKE: begin
                    if (w_empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        w_bin_we    = 1'b1;
                        n_last_time = r_time;
                        n_ent_out   = r_rd_id;
                        if (r_kind == KIND_NORMAL || r_kind == KIND_ENTRY) begin
                            n_wait     = r_time - r_rd_time;
                            n_wait_vld = 1'b1;
                        end
                        n_head = w_head_inc;
                        n_occ  = w_occ_dec;
                    end
                end
                OP_END: begin
                    w_bin_we    = 1'b1;
                    n_last_time = r_time;
                end
                OP_RESTART: begin
                    n_max       = '0;
                    n_last_time = '0;
                end
                OP_DRAIN: begin
                    if (w_empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_ent_out = r_rd_id;
                        n_head    = w_head_inc;
                        n_occ     = w_occ_dec;
                        n_last    = (w_occ_dec == '0);
                        // Stay and fetch the next head while entries remain
                        if (w_occ_dec != '0) begin
                            n_state   = S_EXEC;
                            w_fifo_re = 1'b1;
                        end
                    end
                end
                OP_READ_BIN: begin
                    n_bin_out = r_bidx_oob ? '0 : w_bin_cur;
                end
                default: begin
                end
            endcase
        end
    end

    assign w_fifo_raddr = (r_state == S_IDLE) ? r_head : w_head_inc;

    // Control state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_kind      <= KIND_NORMAL;
            r_head      <= '0;
            r_tail      <= '0;
            r_occ       <= '0;
            r_max       <= '0;
            r_last_time <= '0;
            r_bin_vld   <= '0;
            r_m_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_occ       <= n_occ;
            r_max       <= n_max;
            r_last_time <= n_last_time;
            if (i_cfg_wr_en) begin
                r_kind <= i_cfg_wr_data;
            end
            if (w_bin_we) begin
                r_bin_vld[r_bin_addr] <= 1'b1;
            end
            // Latch the request
            if (w_accept) begin
                r_op       <= w_in_op;
                r_ent      <= s_axis_tdata[ID_W-1:0];
                r_time     <= s_axis_tdata[ID_W +: TIME_W];
                r_bidx_oob <= w_in_oob;
                r_bin_addr <= w_bin_raddr;
            end
            // Load the result, or drop it once taken
            if (w_exec) begin
                r_m_valid <= 1'b1;
                r_m_tdata <= {(M_TDATA_W - ID_W - TIME_W - 2*SIZE_W - BIN_W)'(0),
                              n_bin_out,
                              SIZE_W'(n_max),
                              SIZE_W'(n_occ),
                              n_wait,
                              n_ent_out};
                r_m_tuser <= {n_wait_vld, n_status};
                r_m_tlast <= n_last;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // ID and entry-time memory
    always_ff @(posedge i_clk) begin
        if (w_fifo_we) begin
            mem_id[r_tail]   <= r_ent;
            mem_time[r_tail] <= r_time;
        end
        if (w_fifo_re) begin
            r_rd_id   <= mem_id[w_fifo_raddr];
            r_rd_time <= mem_time[w_fifo_raddr];
        end
    end

    // Histogram bin memory; unwritten bins read as zero through valid bits
    always_ff @(posedge i_clk) begin
        if (w_bin_we) begin
            mem_bin[r_bin_addr] <= w_bin_new;
        end
        if (w_accept) begin
            r_rd_bin     <= mem_bin[w_bin_raddr];
            r_rd_bin_vld <= r_bin_vld[w_bin_raddr];
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_tdata;
    assign m_axis_tuser  = r_m_tuser;
    assign m_axis_tlast  = r_m_tlast;

endmodule

// ===== rtl/fwoh_checker.sv =====
// Port-level checks for the occupancy-histogram FIFO, bound to the top level.
`timescale 1ns / 1ps

module fwoh_checker
    import fwoh_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata,
    input logic [M_TUSER_W-1:0] m_axis_tuser,
    input logic                 m_axis_tlast
);

    // Hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // A dropped add only happens at full occupancy
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1:0] == ST_FULL |->
            m_axis_tdata[52:48] == SIZE_W'(DEPTH) && m_axis_tlast)
        else $error("full status without full queue");

    // An empty status reports an empty queue and ends the request
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1:0] == ST_EMPTY |->
            m_axis_tdata[52:48] == '0 && m_axis_tlast && m_axis_tdata[15:0] == '0)
        else $error("empty status with entries left");

    // A reported wait or a mid-drain result always carries status ok
    a_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser[2] || !m_axis_tlast) |->
            m_axis_tuser[1:0] == ST_OK)
        else $error("wait or drain result with bad status");

endmodule

bind fifo_with_occupancy_histogram fwoh_checker u_fwoh_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
